// ===== rtl/sfla_pkg.sv =====
// Shared types, constants and helpers for the slab free-list allocator.
package sfla_pkg;

  localparam int SLAB_LIMIT  = 16;
  localparam int MAX_OBJECTS = 64;

  localparam int SLAB_W  = 4;   // slab index
  localparam int OBJ_W   = 6;   // object index within a slab
  localparam int CAP_W   = 7;   // per-slab capacity and free count, 0..64
  localparam int CNT_W   = 5;   // number of created slabs, 0..16
  localparam int TOT_W   = 11;  // used and free object totals, 0..1024
  localparam int CTR_W   = 32;  // wrapping transaction counters
  localparam int ADDR_W  = SLAB_W + OBJ_W;
  localparam int CFG_A_W = 1;
  localparam int CFG_D_W = 7;

  // Configuration register indices.
  localparam logic [CFG_A_W-1:0] REG_SLAB_CAPACITY = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_PRESET_SLABS  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLAB_W-1:0] slab;
    logic [OBJ_W-1:0]  obj;
  } item_t;

  typedef struct packed {
    logic [CAP_W-1:0] cap;         // capacity for slabs grown by an allocation
    logic [CNT_W-1:0] target;      // slabs that must exist, already capped
    logic [CAP_W-1:0] target_cap;  // capacity in force when target was written
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [SLAB_W-1:0] slab;
    logic [OBJ_W-1:0]  obj;
    logic [CNT_W-1:0]  created;
    logic [TOT_W-1:0]  used;
    logic [TOT_W-1:0]  spare;
    logic [CTR_W-1:0]  alloc_total;
    logic [CTR_W-1:0]  free_total;
  } res_t;

  // Clamp a requested objects-per-slab value into 1..MAX_OBJECTS.
  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] n);
    logic [CAP_W-1:0] r;
    if (n == '0) begin
      r = CAP_W'(1);
    end else if (n > CAP_W'(MAX_OBJECTS)) begin
      r = CAP_W'(MAX_OBJECTS);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

// ===== rtl/sfla_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sfla_front.sv =====
// Command intake: decodes incoming transactions and holds them in a two-entry queue.
module sfla_front
  import sfla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tuser,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       ent [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  item_t       dec;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = ent[rd_ptr];

  always_comb begin
    dec.cmd  = cmd_t'(s_tuser);
    dec.slab = s_tdata[SLAB_W-1:0];
    dec.obj  = s_tdata[SLAB_W+OBJ_W-1:SLAB_W];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/sfla_back.sv =====
// Allocation engine: per-slab free lists, link memory, slab creation and totals.
module sfla_back
  import sfla_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  input  logic  out_free,
  output logic  res_valid,
  output res_t  res
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_POP   = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]  grown;
  logic [CNT_W-1:0]  grown_next;
  logic [OBJ_W-1:0]  head   [SLAB_LIMIT];
  logic [CAP_W-1:0]  fcount [SLAB_LIMIT];
  logic [CAP_W-1:0]  scap   [SLAB_LIMIT];
  logic [SLAB_LIMIT-1:0] nonempty;
  logic [TOT_W-1:0]  used;
  logic [TOT_W-1:0]  used_next;
  logic [TOT_W-1:0]  fsum;
  logic [TOT_W-1:0]  fsum_next;
  logic [CTR_W-1:0]  alloc_cnt;
  logic [CTR_W-1:0]  alloc_cnt_next;
  logic [CTR_W-1:0]  free_cnt;
  logic [CTR_W-1:0]  free_cnt_next;

  logic [SLAB_W-1:0] cur_slab;
  logic [SLAB_W-1:0] sw_slab;
  logic [OBJ_W-1:0]  sw_idx;
  logic [CAP_W-1:0]  sw_cap;
  logic              sw_last;

  logic [SLAB_W-1:0] sel;
  logic              any_free;
  logic              is_free;
  logic              bad;
  logic              cfg_pending;
  logic              start_sweep;
  logic [CAP_W-1:0]  sweep_cap_sel;
  logic              start_pop;
  logic              do_free_ok;
  logic              do_bad;
  logic              do_oom;
  logic              do_pop;
  logic              do_create;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [OBJ_W-1:0]  ram_wdata;
  logic [OBJ_W-1:0]  ram_rdata;

  // Lowest-numbered slab holding a free object.
  always_comb begin
    sel = '0;
    for (int i = SLAB_LIMIT - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        sel = SLAB_W'(i);
      end
    end
  end

  assign any_free    = |nonempty;
  assign is_free     = (q_item.cmd == CMD_FREE);
  assign cfg_pending = (grown < cfg.target);
  assign bad = ({1'b0, q_item.slab} >= grown) ||
               ({1'b0, q_item.obj} >= scap[q_item.slab]) ||
               (fcount[q_item.slab] >= scap[q_item.slab]);
  assign sw_last   = ({1'b0, sw_idx} == (sw_cap - CAP_W'(1)));
  assign do_create = (state == S_SWEEP) && sw_last;

  always_comb begin
    start_sweep   = 1'b0;
    sweep_cap_sel = cfg.cap;
    start_pop     = 1'b0;
    do_free_ok    = 1'b0;
    do_bad        = 1'b0;
    do_oom        = 1'b0;
    do_pop        = 1'b0;
    state_next    = state;
    unique case (state)
      S_IDLE: begin
        if (cfg_pending) begin
          start_sweep   = 1'b1;
          sweep_cap_sel = cfg.target_cap;
          state_next    = S_SWEEP;
        end else if (q_valid) begin
          if (is_free) begin
            if (out_free) begin
              do_bad     = bad;
              do_free_ok = !bad;
            end
          end else if (any_free) begin
            start_pop  = 1'b1;
            state_next = S_POP;
          end else if (grown != CNT_W'(SLAB_LIMIT)) begin
            // Grow a slab, then come back and retry the allocation.
            start_sweep = 1'b1;
            state_next  = S_SWEEP;
          end else if (out_free) begin
            do_oom = 1'b1;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          do_pop     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sw_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res_valid = do_free_ok || do_bad || do_oom || do_pop;
  assign q_pop     = res_valid;

  always_comb begin
    grown_next     = grown + CNT_W'(do_create);
    used_next      = used + TOT_W'(do_pop) - TOT_W'(do_free_ok);
    fsum_next      = fsum + (do_create ? TOT_W'(sw_cap) : '0)
                     - TOT_W'(do_pop) + TOT_W'(do_free_ok);
    alloc_cnt_next = alloc_cnt + CTR_W'(do_pop);
    free_cnt_next  = free_cnt + CTR_W'(do_free_ok);
  end

  always_comb begin
    priority if (do_bad) begin
      res.status = ST_BAD;
    end else if (do_oom) begin
      res.status = ST_OOM;
    end else begin
      res.status = ST_OK;
    end
    res.slab        = do_pop ? cur_slab : '0;
    res.obj         = do_pop ? head[cur_slab] : '0;
    res.created     = grown_next;
    res.used        = used_next;
    res.spare       = fsum_next;
    res.alloc_total = alloc_cnt_next;
    res.free_total  = free_cnt_next;
  end

  // Link memory: the sweep writes each fresh slab's descending chain, a free
  // pushes the old list head under the returned object.
  always_comb begin
    ram_we = (state == S_SWEEP) || do_free_ok;
    if (state == S_SWEEP) begin
      ram_waddr = {sw_slab, sw_idx};
      ram_wdata = (sw_idx == '0) ? '0 : sw_idx - OBJ_W'(1);
    end else begin
      ram_waddr = {q_item.slab, q_item.obj};
      ram_wdata = head[q_item.slab];
    end
  end

  sfla_ram #(
    .WIDTH (OBJ_W),
    .DEPTH (SLAB_LIMIT * MAX_OBJECTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (start_pop),
    .raddr ({sel, head[sel]}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      grown     <= '0;
      nonempty  <= '0;
      used      <= '0;
      fsum      <= '0;
      alloc_cnt <= '0;
      free_cnt  <= '0;
    end else begin
      state     <= state_next;
      grown     <= grown_next;
      used      <= used_next;
      fsum      <= fsum_next;
      alloc_cnt <= alloc_cnt_next;
      free_cnt  <= free_cnt_next;
      if (do_create) begin
        nonempty[sw_slab] <= 1'b1;
      end else if (do_pop) begin
        nonempty[cur_slab] <= (fcount[cur_slab] != CAP_W'(1));
      end else if (do_free_ok) begin
        nonempty[q_item.slab] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_sweep) begin
      sw_slab <= grown[SLAB_W-1:0];
      sw_idx  <= '0;
      sw_cap  <= sweep_cap_sel;
    end else if (state == S_SWEEP) begin
      sw_idx <= sw_idx + OBJ_W'(1);
    end
    if (start_pop) begin
      cur_slab <= sel;
    end
    if (do_create) begin
      head[sw_slab]   <= OBJ_W'(sw_cap - CAP_W'(1));
      fcount[sw_slab] <= sw_cap;
      scap[sw_slab]   <= sw_cap;
    end else if (do_pop) begin
      head[cur_slab]   <= ram_rdata;
      fcount[cur_slab] <= fcount[cur_slab] - CAP_W'(1);
    end else if (do_free_ok) begin
      head[q_item.slab]   <= q_item.obj;
      fcount[q_item.slab] <= fcount[q_item.slab] + CAP_W'(1);
    end
  end

endmodule

// ===== rtl/slab_free_list_allocator_core.sv =====
// Slab free-list allocator: top level with configuration registers and result register.
//
// Each input transaction is an allocate or a free command, and each one yields
// exactly one result transaction. Objects live in up to 16 slabs of up to 64
// objects; every slab keeps a LIFO free list whose links sit in a 1024-entry
// link RAM. An allocation takes from the lowest-numbered created slab that has a
// free object in two steps: the first looks up the slab's list head and reads
// its link word from the RAM, the second takes the data back and updates the
// list once the result register is free. A free, an invalid free and an
// out-of-memory answer are given straight from the idle state. Creating a slab
// writes its fresh chain into the link RAM one entry a cycle once the sweep is
// set up, so an allocation that must grow a new slab waits for that sweep, and
// a write to the preset slab count keeps the engine busy sweeping each slab it
// creates before queued commands are served. A two-entry command queue sits
// between intake and the engine, and the result register frees the engine from
// the consumer, so either side may stall freely. Slab capacity is fixed when the
// slab is created; later writes to the capacity register affect only slabs
// created afterwards.
module slab_free_list_allocator_core
  import sfla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Command stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // handle_slab[3:0], handle_object[9:4], zeros
  input  logic                s_tuser,   // command: 0 allocate, 1 free
  // Result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [103:0]        m_tdata,   // slab_index[3:0], object_index[9:4],
                                         // created_slabs[14:10], used_objects[25:15],
                                         // spare_objects[36:26], alloc_total[68:37],
                                         // free_total[100:69], zeros
  output logic [1:0]          m_tuser,   // status: 0 ok, 1 out of memory, 2 invalid
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [CFG_D_W-1:0]  cfg_wdata
);

  logic [CAP_W-1:0] obj_per_slab;
  logic [CNT_W-1:0] preset_target;
  logic [CAP_W-1:0] preset_cap;
  cfg_t             cfg;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;
  logic             out_free;
  logic             res_valid;
  res_t             res;

  // Configuration registers. A write to the preset slab count records the slab
  // target together with the capacity then in force, which the engine uses when
  // it creates those slabs.
  always_ff @(posedge clk) begin
    if (rst) begin
      obj_per_slab  <= CAP_W'(MAX_OBJECTS);
      preset_target <= '0;
      preset_cap    <= CAP_W'(MAX_OBJECTS);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SLAB_CAPACITY: begin
          obj_per_slab <= cfg_wdata;
        end
        REG_PRESET_SLABS: begin
          preset_target <= (cfg_wdata[CNT_W-1:0] > CNT_W'(SLAB_LIMIT)) ?
                           CNT_W'(SLAB_LIMIT) : cfg_wdata[CNT_W-1:0];
          preset_cap    <= eff_cap(obj_per_slab);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.cap        = eff_cap(obj_per_slab);
    cfg.target     = preset_target;
    cfg.target_cap = preset_cap;
  end

  sfla_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sfla_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: the engine may load it whenever it is empty or being
  // drained in the same cycle.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tuser <= res.status;
      m_tdata <= {3'b000, res.free_total, res.alloc_total, res.spare,
                  res.used, res.created, res.obj, res.slab};
    end
  end

`ifndef SYNTHESIS
  // The engine never overwrites a result the consumer has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result produced while the output register is held");

  // Every result retires a command that is actually in the queue.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> q_valid)
    else $error("result produced with an empty command queue");

  // Out of memory is only reported once every slab has been created.
  a_oom_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_OOM) |-> (res.created == CNT_W'(SLAB_LIMIT)))
    else $error("out of memory reported with slabs still available");
`endif

endmodule
